// File: rtl/cfd8_pkg.sv
`timescale 1ns / 1ps

package cfd8_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int INDEX_W     = 6;
    localparam int CFG_W       = 4;
    localparam int DECIM       = 8;
    localparam int DECIM_LOG2  = 3;
    localparam int SCALE_SHIFT = 17;
    localparam int SCALE_BIAS  = 131071;
    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W        = 2;
    localparam int PROD_W      = SAMPLE_W + COEF_W;

    typedef logic [CFG_W-1:0] t_tap_blocks;

    typedef struct packed {
        logic                       mode;
        logic signed [SAMPLE_W-1:0] sample_i;
        logic signed [SAMPLE_W-1:0] sample_q;
        logic [INDEX_W-1:0]         tap_index;
        logic signed [COEF_W-1:0]   tap_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_i;
        logic signed [SAMPLE_W-1:0] out_q;
        logic                       overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_SAMPLE_LAST,
        CMD_COEF
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                  kind;
        logic signed [SAMPLE_W-1:0] sample_i;
        logic signed [SAMPLE_W-1:0] sample_q;
        logic [INDEX_W-1:0]         tap_index;
        logic signed [COEF_W-1:0]   tap_value;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SETUP,
        BK_MAC,
        BK_DRAIN,
        BK_OUT
    } t_back_state;

endpackage

// File: rtl/cfd8_stream_if.sv
`timescale 1ns / 1ps

interface cfd8_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/cfd8_ram.sv
`timescale 1ns / 1ps

module cfd8_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/cfd8_front.sv
`timescale 1ns / 1ps

module cfd8_front
    import cfd8_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfd8_stream_if.sink   i_in,
    cfd8_stream_if.source o_cmd
);

    logic [DECIM_LOG2-1:0] r_phase;
    t_cmd                  cmd;

    always_comb begin
        cmd.sample_i  = i_in.data.sample_i;
        cmd.sample_q  = i_in.data.sample_q;
        cmd.tap_index = i_in.data.tap_index;
        cmd.tap_value = i_in.data.tap_value;
        priority if (i_in.data.mode) begin
            cmd.kind = CMD_COEF;
        end else if (r_phase == DECIM_LOG2'(DECIM - 1)) begin
            cmd.kind = CMD_SAMPLE_LAST;
        end else begin
            cmd.kind = CMD_SAMPLE;
        end
    end

    assign o_cmd.valid = i_in.valid;
    assign o_cmd.data  = cmd;
    assign i_in.ready  = o_cmd.ready;

    // block phase counts samples only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_in.valid && o_cmd.ready && !i_in.data.mode) begin
            r_phase <= r_phase + DECIM_LOG2'(1);
        end
    end

endmodule

// File: rtl/cfd8_queue.sv
`timescale 1ns / 1ps

module cfd8_queue
    import cfd8_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfd8_stream_if.sink   i_push,
    cfd8_stream_if.source o_pop
);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr;
    logic [QP_W-1:0] r_rd;
    logic [QP_W:0]   r_count;
    logic            push;
    logic            pop;

    assign i_push.ready = (r_count != (QP_W + 1)'(QUEUE_DEPTH));
    assign o_pop.valid  = (r_count != '0);
    assign o_pop.data   = r_mem[r_rd];

    assign push = i_push.valid && i_push.ready;
    assign pop  = o_pop.valid && o_pop.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QP_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QP_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (QP_W + 1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (QP_W + 1)'(1);
            end
        end
    end

endmodule

// File: rtl/cfd8_back.sv
`timescale 1ns / 1ps

module cfd8_back
    import cfd8_pkg::*;
#(
    parameter int MAX_TAPS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_tap_blocks   i_tap_blocks,
    cfd8_stream_if.sink   i_cmd,
    cfd8_stream_if.source o_out
);

    localparam int LINE_LEN = MAX_TAPS + DECIM;
    localparam int HA_W     = $clog2(LINE_LEN);
    localparam int CA_W     = $clog2(MAX_TAPS);
    localparam int F_W      = $clog2(LINE_LEN + 1);
    localparam int T_W      = $clog2(MAX_TAPS + 1);
    localparam int BX_W     = CFG_W + T_W;
    localparam int MAXB     = MAX_TAPS / DECIM;
    localparam int IX_W     = CA_W + INDEX_W;
    localparam int ACC_W    = PROD_W + CA_W + 1;
    localparam int Q_W      = ACC_W - SCALE_SHIFT;

    t_back_state r_state;
    t_back_state n_state;

    logic [HA_W-1:0]     r_wp;
    logic [F_W-1:0]      r_fill;
    logic [MAX_TAPS-1:0] r_cvalid;
    logic [CA_W-1:0]     r_j;
    logic [HA_W-1:0]     r_haddr;
    logic [HA_W-1:0]     r_age;
    logic [T_W-1:0]      r_cnt;
    logic                r_s1_valid;
    logic                r_s1_ok;
    logic                r_s2_valid;
    logic signed [PROD_W-1:0] r_p_i;
    logic signed [PROD_W-1:0] r_p_q;
    logic signed [ACC_W-1:0]  r_acc_i;
    logic signed [ACC_W-1:0]  r_acc_q;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                hist_we;
    logic                coef_we;
    logic                mac_load;
    logic                issue;
    logic                out_load;
    logic [BX_W-1:0]     b_ext;
    logic [T_W-1:0]      taps;
    logic [HA_W:0]       start_sum;
    logic [HA_W-1:0]     start_addr;
    logic [IX_W-1:0]     idx_wide;
    logic                idx_ok;
    logic                tap_ok;
    logic [2*SAMPLE_W-1:0] hist_rdata;
    logic [COEF_W-1:0]     coef_rdata;
    logic signed [PROD_W-1:0] prod_i;
    logic signed [PROD_W-1:0] prod_q;
    logic [ACC_W-1:0]    rnd_i;
    logic [ACC_W-1:0]    rnd_q;
    logic [Q_W-1:0]      quo_i;
    logic [Q_W-1:0]      quo_q;
    logic [Q_W-SAMPLE_W:0] hi_i;
    logic [Q_W-SAMPLE_W:0] hi_q;

    cfd8_ram #(
        .WIDTH(2 * SAMPLE_W),
        .DEPTH(LINE_LEN)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (hist_we),
        .i_waddr(r_wp),
        .i_wdata({i_cmd.data.sample_q, i_cmd.data.sample_i}),
        .i_raddr(r_haddr),
        .o_rdata(hist_rdata)
    );

    cfd8_ram #(
        .WIDTH(COEF_W),
        .DEPTH(MAX_TAPS)
    ) u_coef (
        .i_clk  (i_clk),
        .i_we   (coef_we),
        .i_waddr(idx_wide[CA_W-1:0]),
        .i_wdata(i_cmd.data.tap_value),
        .i_raddr(r_j),
        .o_rdata(coef_rdata)
    );

    // tap count and start of the window in the history ring
    always_comb begin
        b_ext = BX_W'(i_tap_blocks);
        if (b_ext == '0) begin
            b_ext = BX_W'(1);
        end
        if (b_ext > BX_W'(MAXB)) begin
            b_ext = BX_W'(MAXB);
        end
        taps = T_W'(b_ext << DECIM_LOG2);
        start_sum = (HA_W + 1)'(r_wp) + (HA_W + 1)'(LINE_LEN) - (HA_W + 1)'(DECIM)
                  - (HA_W + 1)'(taps);
        if (start_sum >= (HA_W + 1)'(LINE_LEN)) begin
            start_sum = start_sum - (HA_W + 1)'(LINE_LEN);
        end
        start_addr = start_sum[HA_W-1:0];
    end

    assign idx_wide = IX_W'(i_cmd.data.tap_index);
    assign idx_ok   = (idx_wide < IX_W'(MAX_TAPS));
    assign tap_ok   = (F_W'(r_age) < r_fill) && r_cvalid[r_j];

    always_comb begin
        n_state     = r_state;
        i_cmd.ready = 1'b0;
        hist_we     = 1'b0;
        coef_we     = 1'b0;
        mac_load    = 1'b0;
        issue       = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    unique case (i_cmd.data.kind)
                        CMD_COEF: begin
                            coef_we = idx_ok;
                        end
                        CMD_SAMPLE: begin
                            hist_we = 1'b1;
                        end
                        CMD_SAMPLE_LAST: begin
                            hist_we = 1'b1;
                            n_state = BK_SETUP;
                        end
                        default: begin
                            n_state = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_SETUP: begin
                mac_load = 1'b1;
                n_state  = BK_MAC;
            end
            BK_MAC: begin
                issue = 1'b1;
                if (r_cnt == T_W'(1)) begin
                    n_state = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (!r_s1_valid && !r_s2_valid) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // history ring write side and coefficient valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_fill   <= '0;
            r_cvalid <= '0;
        end else begin
            if (hist_we) begin
                r_wp <= (r_wp == HA_W'(LINE_LEN - 1)) ? '0 : r_wp + HA_W'(1);
                if (r_fill != F_W'(LINE_LEN)) begin
                    r_fill <= r_fill + F_W'(1);
                end
            end
            if (coef_we) begin
                r_cvalid[idx_wide[CA_W-1:0]] <= 1'b1;
            end
        end
    end

    // tap walk
    always_ff @(posedge i_clk) begin
        if (mac_load) begin
            r_haddr <= start_addr;
            r_age   <= HA_W'(taps) + HA_W'(DECIM - 1);
            r_cnt   <= taps;
            r_j     <= '0;
        end else if (issue) begin
            r_haddr <= (r_haddr == HA_W'(LINE_LEN - 1)) ? '0 : r_haddr + HA_W'(1);
            r_age   <= r_age - HA_W'(1);
            r_cnt   <= r_cnt - T_W'(1);
            r_j     <= r_j + CA_W'(1);
        end
    end

    assign prod_i = $signed(hist_rdata[SAMPLE_W-1:0]) * $signed(coef_rdata);
    assign prod_q = $signed(hist_rdata[2*SAMPLE_W-1:SAMPLE_W]) * $signed(coef_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ok <= tap_ok;
        if (r_s1_valid) begin
            r_p_i <= r_s1_ok ? prod_i : PROD_W'(0);
            r_p_q <= r_s1_ok ? prod_q : PROD_W'(0);
        end
        if (mac_load) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_s2_valid) begin
            r_acc_i <= r_acc_i + ACC_W'(r_p_i);
            r_acc_q <= r_acc_q + ACC_W'(r_p_q);
        end
    end

    // divide by 2^17 rounding toward zero
    always_comb begin
        rnd_i = r_acc_i + (r_acc_i[ACC_W-1] ? ACC_W'(SCALE_BIAS) : ACC_W'(0));
        rnd_q = r_acc_q + (r_acc_q[ACC_W-1] ? ACC_W'(SCALE_BIAS) : ACC_W'(0));
        quo_i = rnd_i[ACC_W-1:SCALE_SHIFT];
        quo_q = rnd_q[ACC_W-1:SCALE_SHIFT];
        hi_i  = quo_i[Q_W-1:SAMPLE_W-1];
        hi_q  = quo_q[Q_W-1:SAMPLE_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.out_i    <= quo_i[SAMPLE_W-1:0];
            r_out.out_q    <= quo_q[SAMPLE_W-1:0];
            r_out.overflow <= !((&hi_i) || (~|hi_i)) || !((&hi_q) || (~|hi_q));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

// File: rtl/complex_fir_decimator_by_eight_core.sv
`timescale 1ns / 1ps

// Complex FIR decimator by eight. Input transfers carry either a complex sample
// (mode 0) or a coefficient write into the tap table (mode 1); after every eighth
// sample one complex result is produced, the tap-weighted sum over the history
// ahead of the latest block of eight, divided by 2^17 toward zero and wrapped to
// 16 bits with an overflow flag. The tap table and history read as zero after
// reset. Input transfers pass through a four-entry command queue. The back end
// walks taps = 8 * tap_blocks (clamped to 1..MAX_TAPS/8) with a single complex
// multiply-accumulate, one tap per cycle over the one read port of the history
// RAM, and takes no new command until its result is loaded. The queue absorbs
// input while the accumulation runs.
module complex_fir_decimator_by_eight_core
    import cfd8_pkg::*;
#(
    parameter int MAX_TAPS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfd8_stream_if.sink   i_cfg,
    cfd8_stream_if.sink   i_in,
    cfd8_stream_if.source o_out
);

    t_tap_blocks r_tap_blocks;

    cfd8_stream_if #(.T(t_cmd)) q_fr ();
    cfd8_stream_if #(.T(t_cmd)) q_bk ();

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_blocks <= CFG_W'(DECIM);
        end else if (i_cfg.valid) begin
            r_tap_blocks <= i_cfg.data;
        end
    end

    cfd8_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .o_cmd  (q_fr)
    );

    cfd8_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_fr),
        .o_pop  (q_bk)
    );

    cfd8_back #(
        .MAX_TAPS(MAX_TAPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tap_blocks(r_tap_blocks),
        .i_cmd       (q_bk),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_bk.valid && q_bk.ready && q_bk.data.kind == CMD_SAMPLE_LAST) |=> !q_bk.ready)
        else $error("back end took a command during accumulation");

    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!q_bk.ready))
        else $error("result appeared without an accumulation pass");

    a_queue_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_fr.valid && q_fr.ready) |=> q_bk.valid)
        else $error("queue lost a pushed command");
`endif

endmodule
